/* rtl/bgr_pkg.sv */
// shared constants, types and the glyph rom of the 5x7 glyph rectangle rasterizer
// used by bgr_cell_gen, bgr_geom and bitmap_glyph_rect_rasterizer_core
// no dependencies
package bgr_pkg;

    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_CELLS = GLYPH_ROWS * GLYPH_COLS;
    localparam int GLYPH_COUNT = 42;
    localparam int ADVANCE     = 6;

    localparam int CODE_W  = 8;
    localparam int CPOS_W  = 10;
    localparam int ORG_W   = 16;
    localparam int COLOR_W = 32;
    localparam int SCALE_W = 4;
    localparam int ZOOM_W  = 10;
    localparam int S_W     = SCALE_W + ZOOM_W;
    localparam int K_W     = 13;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int KS_W    = K_W + S_W;
    localparam int RS_W    = ROW_W + S_W;
    localparam int SUM_W   = KS_W + 2;
    localparam int EDGE_W  = SUM_W - 8;
    localparam int POS_W   = 18;
    localparam int SIZE_W  = 16;
    localparam int GIDX_W  = 6;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 104;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM_Q8    = 2'd1;

    localparam logic [SCALE_W-1:0] TEXT_SCALE_RESET = 4'd1;
    localparam logic [ZOOM_W-1:0]  ZOOM_RESET       = 10'd256;
    // 0.35 in q6.8, rounded up
    localparam logic [S_W-1:0]     MIN_SCALE_Q8     = 14'd90;

    localparam logic signed [EDGE_W-1:0] POS_MAX_E = EDGE_W'(131071);
    localparam logic signed [EDGE_W-1:0] POS_MIN_E = -EDGE_W'(131072);
    localparam logic signed [EDGE_W:0]   SIZE_MIN  = (EDGE_W + 1)'(1);
    localparam logic signed [EDGE_W:0]   SIZE_MAX  = (EDGE_W + 1)'(65535);

    // ascii codes with special meaning
    localparam logic [CODE_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CODE_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CODE_W-1:0] CH_LO_J  = 8'h6A;
    localparam logic [CODE_W-1:0] CH_LO_Q  = 8'h71;
    localparam logic [CODE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CODE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CODE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CODE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CODE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CODE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CODE_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CODE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CODE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CODE_W-1:0] CH_EQUAL = 8'h3D;

    localparam logic [GIDX_W-1:0] GLYPH_I     = 6'd8;
    localparam logic [GIDX_W-1:0] GLYPH_O     = 6'd14;
    localparam logic [GIDX_W-1:0] GLYPH_DIGIT = 6'd26;
    localparam logic [GIDX_W-1:0] GLYPH_DOT   = 6'd36;
    localparam logic [GIDX_W-1:0] GLYPH_MINUS = 6'd37;
    localparam logic [GIDX_W-1:0] GLYPH_UNDER = 6'd38;
    localparam logic [GIDX_W-1:0] GLYPH_PLUS  = 6'd39;
    localparam logic [GIDX_W-1:0] GLYPH_COLON = 6'd40;
    localparam logic [GIDX_W-1:0] GLYPH_EQUAL = 6'd41;
    localparam logic [GIDX_W-1:0] GLYPH_BLANK = 6'd63;

    // rows top first, leftmost column in bit 4; letters (J and Q blank), digits, . - _ + : =
    localparam logic [GLYPH_COLS-1:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
        '{5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F},
        '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
        '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
        '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h1C},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06},
        '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F},
        '{5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00},
        '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
        '{5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}
    };

    // one lit cell on its way from the cell generator to the geometry pipeline
    typedef struct packed {
        logic [K_W-1:0]           k;
        logic [ROW_W-1:0]         row;
        logic [S_W-1:0]           s;
        logic signed [ORG_W-1:0]  ox;
        logic signed [ORG_W-1:0]  oy;
        logic [COLOR_W-1:0]       color;
        logic                     last;
    } cell_t;

    function automatic logic [GIDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
        logic [GIDX_W-1:0] g;
        case (code) inside
            CH_LO_J:              g = GLYPH_I;
            CH_LO_Q:              g = GLYPH_O;
            [CH_LO_A:CH_LO_Z]:    g = GIDX_W'(code - CH_LO_A);
            [CH_UP_A:CH_UP_Z]:    g = GIDX_W'(code - CH_UP_A);
            [CH_ZERO:CH_NINE]:    g = GIDX_W'(code - CH_ZERO) + GLYPH_DIGIT;
            CH_DOT:               g = GLYPH_DOT;
            CH_MINUS:             g = GLYPH_MINUS;
            CH_UNDER:             g = GLYPH_UNDER;
            CH_PLUS:              g = GLYPH_PLUS;
            CH_COLON:             g = GLYPH_COLON;
            CH_EQUAL:             g = GLYPH_EQUAL;
            default:              g = GLYPH_BLANK;
        endcase
        return g;
    endfunction

    // lit cells in raster order, bit 0 is the top left cell
    function automatic logic [GLYPH_CELLS-1:0] glyph_mask(input logic [GIDX_W-1:0] g);
        logic [GLYPH_CELLS-1:0] m;
        m = '0;
        if (g < GIDX_W'(GLYPH_COUNT))
        begin
            for (int r = 0; r < GLYPH_ROWS; r++)
            begin
                for (int c = 0; c < GLYPH_COLS; c++)
                begin
                    m[r * GLYPH_COLS + c] = GLYPH_ROM[g][r][GLYPH_COLS - 1 - c];
                end
            end
        end
        return m;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [EDGE_W-1:0] e);
        logic [POS_W-1:0] p;
        if (e > POS_MAX_E)
            p = POS_MAX_E[POS_W-1:0];
        else if (e < POS_MIN_E)
            p = POS_MIN_E[POS_W-1:0];
        else
            p = e[POS_W-1:0];
        return p;
    endfunction

    function automatic logic [SIZE_W-1:0] size_of(input logic signed [EDGE_W-1:0] lo,
                                                  input logic signed [EDGE_W-1:0] hi);
        logic signed [EDGE_W:0] d;
        logic [SIZE_W-1:0]      z;
        d = {hi[EDGE_W-1], hi} - {lo[EDGE_W-1], lo};
        if (d < SIZE_MIN)
            z = SIZE_MIN[SIZE_W-1:0];
        else if (d > SIZE_MAX)
            z = SIZE_MAX[SIZE_W-1:0];
        else
            z = d[SIZE_W-1:0];
        return z;
    endfunction

endpackage

/* rtl/bitmap_glyph_rect_rasterizer_core.sv */
// top level of the 5x7 glyph rectangle rasterizer: config registers, stream ports
// depends on bgr_pkg, bgr_cell_gen and bgr_geom
//
// usage: one character item enters on s_axis (code, string index, origin, colour);
// each lit cell of its 5x7 glyph leaves on m_axis as one filled rectangle in
// raster order, tlast marking the final rectangle of the character. blank glyphs
// and text_scale 0 produce no rectangle at all.
// config: cfg_we with cfg_index 0 writes text_scale, index 1 writes zoom_q8
// (q2.8); other indexes are ignored. write only while no item is in flight.
// throughput: the cell walker steps one glyph cell per cycle, unless a lit cell
// is stalled, from the top left up to the last lit cell; a blank glyph never
// makes it busy. the next item is taken in the cycle the last lit cell moves on.
// path: a lit cell reaches m_axis through the product, edge and clamp stages.
// reset: text_scale returns to 1, zoom_q8 to 256 (unit scale), pipeline empties.
// stall: a low m_axis_tready freezes the output stage and back-pressures the
// pipeline and the walker; nothing is dropped or repeated.
module bitmap_glyph_rect_rasterizer_core
    import bgr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // char_code, char_pos, origin_x, origin_y, color_rgba, zero fill
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // rect_x, rect_y, rect_w, rect_h, rect_color, zero fill
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                    m_axis_tlast
);

    logic [SCALE_W-1:0]  text_scale_reg;
    logic [ZOOM_W-1:0]   zoom_reg;

    logic                cell_valid;
    logic                cell_ready;
    cell_t               lit_cell;

    logic [POS_W-1:0]    rect_x;
    logic [POS_W-1:0]    rect_y;
    logic [SIZE_W-1:0]   rect_w;
    logic [SIZE_W-1:0]   rect_h;
    logic [COLOR_W-1:0]  rect_color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_scale_reg <= TEXT_SCALE_RESET;
            zoom_reg       <= ZOOM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEXT_SCALE: text_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_ZOOM_Q8:    zoom_reg       <= cfg_data[ZOOM_W-1:0];
                default:        ;
            endcase
        end
    end

    bgr_cell_gen u_cell_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_scale (text_scale_reg),
        .zoom_q8    (zoom_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .char_code  (s_axis_tdata[7:0]),
        .char_pos   (s_axis_tdata[17:8]),
        .origin_x   (s_axis_tdata[33:18]),
        .origin_y   (s_axis_tdata[49:34]),
        .color_rgba (s_axis_tdata[81:50]),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .lit_cell   (lit_cell)
    );

    bgr_geom u_geom (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cell_valid),
        .in_ready   (cell_ready),
        .lit_cell   (lit_cell),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .rect_x     (rect_x),
        .rect_y     (rect_y),
        .rect_w     (rect_w),
        .rect_h     (rect_h),
        .rect_color (rect_color),
        .last_rect  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, rect_color, rect_h, rect_w, rect_y, rect_x};

endmodule

/* rtl/bgr_cell_gen.sv */
// cell generator: glyph lookup, draw scale, and a walk over the glyph cells
// one cell a cycle up to the last lit one, unless a lit cell is stalled; depends on bgr_pkg
module bgr_cell_gen
    import bgr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [SCALE_W-1:0]        text_scale,
    input  logic [ZOOM_W-1:0]         zoom_q8,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CODE_W-1:0]         char_code,
    input  logic [CPOS_W-1:0]         char_pos,
    input  logic signed [ORG_W-1:0]   origin_x,
    input  logic signed [ORG_W-1:0]   origin_y,
    input  logic [COLOR_W-1:0]        color_rgba,
    output logic                      cell_valid,
    input  logic                      cell_ready,
    output cell_t                     lit_cell
);

    logic                     busy_reg;
    logic [GLYPH_CELLS-1:0]   rem_reg;
    logic [COL_W-1:0]         col_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [K_W-1:0]           k_reg;
    logic [K_W-1:0]           base_reg;
    logic [S_W-1:0]           s_reg;
    logic signed [ORG_W-1:0]  ox_reg;
    logic signed [ORG_W-1:0]  oy_reg;
    logic [COLOR_W-1:0]       color_reg;

    logic [S_W-1:0]           prod;
    logic [S_W-1:0]           s_next;
    logic [GLYPH_CELLS-1:0]   mask;
    logic [K_W-1:0]           base;
    logic                     draw;
    logic                     last_step;
    logic                     adv;
    logic                     take;

    assign prod   = S_W'(text_scale) * S_W'(zoom_q8);
    assign s_next = (prod < MIN_SCALE_Q8) ? MIN_SCALE_Q8 : prod;
    assign mask   = glyph_mask(glyph_index(char_code));
    assign draw   = (text_scale != '0) && (mask != '0);
    // first cell column of this character: 6 * pos
    assign base   = K_W'({char_pos, 2'b00}) + K_W'({char_pos, 1'b0});

    // while busy the remaining mask is never empty, so this cell is the last lit one
    assign last_step = (rem_reg[GLYPH_CELLS-1:1] == '0);
    assign adv       = busy_reg && (!rem_reg[0] || cell_ready);
    assign in_ready  = !busy_reg || (last_step && adv);
    assign take      = in_valid && in_ready;

    assign cell_valid = busy_reg && rem_reg[0];
    assign lit_cell   = '{k: k_reg, row: row_reg, s: s_reg, ox: ox_reg, oy: oy_reg,
                          color: color_reg, last: last_step};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (take)
        begin
            busy_reg <= draw;
        end
        else if (adv)
        begin
            busy_reg <= !last_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rem_reg   <= mask;
            col_reg   <= '0;
            row_reg   <= '0;
            k_reg     <= base;
            base_reg  <= base;
            s_reg     <= s_next;
            ox_reg    <= origin_x;
            oy_reg    <= origin_y;
            color_reg <= color_rgba;
        end
        else if (adv)
        begin
            rem_reg <= rem_reg >> 1;
            if (col_reg == COL_W'(GLYPH_COLS - 1))
            begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
                k_reg   <= base_reg;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
                k_reg   <= k_reg + 1'b1;
            end
        end
    end

    a_busy_has_cells: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg != '0))
        else $error("cell generator busy with no lit cell left");

    a_cell_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !cell_ready |=> cell_valid && $stable(lit_cell))
        else $error("stalled cell changed");

endmodule

/* rtl/bgr_geom.sv */
// geometry pipeline: multiply, add origin and floor, then clamp and size
// three register stages with valid bits; depends on bgr_pkg
module bgr_geom
    import bgr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cell_t                lit_cell,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_W-1:0]     rect_x,
    output logic [POS_W-1:0]     rect_y,
    output logic [SIZE_W-1:0]    rect_w,
    output logic [SIZE_W-1:0]    rect_h,
    output logic [COLOR_W-1:0]   rect_color,
    output logic                 last_rect
);

    // stage a: products
    logic                     va_reg;
    logic [KS_W-1:0]          ks_reg;
    logic [RS_W-1:0]          rs_reg;
    logic [S_W-1:0]           sa_reg;
    logic signed [ORG_W-1:0]  oxa_reg;
    logic signed [ORG_W-1:0]  oya_reg;
    logic [COLOR_W-1:0]       ca_reg;
    logic                     la_reg;
    // stage b: floored edges
    logic                     vb_reg;
    logic signed [EDGE_W-1:0] x0_reg;
    logic signed [EDGE_W-1:0] x1_reg;
    logic signed [EDGE_W-1:0] y0_reg;
    logic signed [EDGE_W-1:0] y1_reg;
    logic [COLOR_W-1:0]       cb_reg;
    logic                     lb_reg;
    // stage c: output
    logic                     vc_reg;
    logic [POS_W-1:0]         x_reg;
    logic [POS_W-1:0]         y_reg;
    logic [SIZE_W-1:0]        w_reg;
    logic [SIZE_W-1:0]        h_reg;
    logic [COLOR_W-1:0]       cc_reg;
    logic                     lc_reg;

    logic                     rdy_a;
    logic                     rdy_b;
    logic                     rdy_c;
    logic signed [SUM_W-1:0]  oxs;
    logic signed [SUM_W-1:0]  oys;
    logic signed [SUM_W-1:0]  xs0;
    logic signed [SUM_W-1:0]  xs1;
    logic signed [SUM_W-1:0]  ys0;
    logic signed [SUM_W-1:0]  ys1;

    assign rdy_c    = !vc_reg || out_ready;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    // positions in 1/256 pixel; the upper bits of the sum are the floor
    assign oxs = {{(SUM_W - ORG_W - 8){oxa_reg[ORG_W-1]}}, oxa_reg, 8'h00};
    assign oys = {{(SUM_W - ORG_W - 8){oya_reg[ORG_W-1]}}, oya_reg, 8'h00};
    assign xs0 = oxs + signed'({{(SUM_W - KS_W){1'b0}}, ks_reg});
    assign xs1 = xs0 + signed'({{(SUM_W - S_W){1'b0}}, sa_reg});
    assign ys0 = oys + signed'({{(SUM_W - RS_W){1'b0}}, rs_reg});
    assign ys1 = ys0 + signed'({{(SUM_W - S_W){1'b0}}, sa_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                va_reg <= in_valid;
            if (rdy_b)
                vb_reg <= va_reg;
            if (rdy_c)
                vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy_a)
        begin
            ks_reg  <= KS_W'(lit_cell.k) * KS_W'(lit_cell.s);
            rs_reg  <= RS_W'(lit_cell.row) * RS_W'(lit_cell.s);
            sa_reg  <= lit_cell.s;
            oxa_reg <= lit_cell.ox;
            oya_reg <= lit_cell.oy;
            ca_reg  <= lit_cell.color;
            la_reg  <= lit_cell.last;
        end
        if (va_reg && rdy_b)
        begin
            x0_reg <= xs0[SUM_W-1:8];
            x1_reg <= xs1[SUM_W-1:8];
            y0_reg <= ys0[SUM_W-1:8];
            y1_reg <= ys1[SUM_W-1:8];
            cb_reg <= ca_reg;
            lb_reg <= la_reg;
        end
        if (vb_reg && rdy_c)
        begin
            x_reg  <= sat_pos(x0_reg);
            y_reg  <= sat_pos(y0_reg);
            w_reg  <= size_of(x0_reg, x1_reg);
            h_reg  <= size_of(y0_reg, y1_reg);
            cc_reg <= cb_reg;
            lc_reg <= lb_reg;
        end
    end

    assign out_valid  = vc_reg;
    assign rect_x     = x_reg;
    assign rect_y     = y_reg;
    assign rect_w     = w_reg;
    assign rect_h     = h_reg;
    assign rect_color = cc_reg;
    assign last_rect  = lc_reg;

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg |-> (w_reg != '0) && (h_reg != '0))
        else $error("rectangle with zero size");

    a_stage_a_holds: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg && !rdy_b |=> va_reg && $stable(ks_reg) && $stable(la_reg))
        else $error("product stage lost an item under stall");

endmodule
